>>> hw/rtl/crom_pkg.sv
// ----------------------------------------------------------------------------
// crom_pkg
// Shared types, constants and helper functions of the ROM header checksum.
// ----------------------------------------------------------------------------
package crom_pkg;

   // key table geometry
   localparam int unsigned KEY_WORDS = 64;
   localparam int unsigned KEY_AW    = $clog2(KEY_WORDS);
   localparam int unsigned WORD_W    = 32;

   typedef logic [KEY_AW-1:0] count_type;
   typedef logic [WORD_W-1:0] word_type;

   // item operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DATA = 1'b1;

   // boot variants
   typedef enum logic [1:0] {
      VAR_6102 = 2'd0,
      VAR_6103 = 2'd1,
      VAR_6105 = 2'd2,
      VAR_6106 = 2'd3
   } variant_type;

   // accumulator seeds
   localparam word_type SEED_6102 = 32'hF8CA4DDC;
   localparam word_type SEED_6103 = 32'hA3886759;
   localparam word_type SEED_6105 = 32'hDF26F436;
   localparam word_type SEED_6106 = 32'h1FEA617A;

   // input item
   typedef struct packed {
      logic      op;
      word_type  word;
      count_type key_index;
      logic      last;
   } req_type;

   // result item
   typedef struct packed {
      word_type sum_first;
      word_type sum_second;
   } rsp_type;

   // the six accumulators
   typedef struct packed {
      word_type mix;
      word_type cmp;
      word_type xr;
      word_type carry;
      word_type rot;
      word_type sum;
   } acc_type;

   // seed word of a variant
   function automatic word_type seed_of(variant_type v);
      word_type s;
      unique case (v)
         VAR_6102: s = SEED_6102;
         VAR_6103: s = SEED_6103;
         VAR_6105: s = SEED_6105;
         VAR_6106: s = SEED_6106;
         default:  s = SEED_6102;
      endcase
      return s;
   endfunction

   // all six accumulators at one seed
   function automatic acc_type seeded(word_type s);
      acc_type a;
      a.mix   = s;
      a.cmp   = s;
      a.xr    = s;
      a.carry = s;
      a.rot   = s;
      a.sum   = s;
      return a;
   endfunction

   // rotate left by 0..31
   function automatic word_type rotl(word_type w, logic [4:0] n);
      logic [2*WORD_W-1:0] t;
      t = {w, w} << n;
      return t[2*WORD_W-1:WORD_W];
   endfunction

endpackage

>>> hw/rtl/cartridge_rom_checksum.sv
// ----------------------------------------------------------------------------
// cartridge_rom_checksum
// Six-accumulator ROM header checksum with a 64-word key table.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries load items (op = 0, writes key_table[key_index]) and
//   data items (op = 1, one big-endian ROM word, last marks the region end).
//   rsp channel gives one item (sum_first, sum_second) for each last word.
//   csr_wr_en / csr_wr_data select the boot variant; a write reseeds the
//   accumulators and clears the word count, the key table is kept. Write it
//   only while no item is in flight.
// Throughput: one item per cycle while req_stall is low, set by the accumulator loop.
// Result path: a last word passes the input register, snapshot,
//   multiply/xor stage and output register on its way to rsp_valid.
// Reset: variant 6102, accumulators at its seed, word count zero, key
//   table contents undefined until loaded.
// Stall: with rsp_stall high the finish stages fill up; req_stall rises only
//   when a last word finds no room in them, other items keep flowing.
// ----------------------------------------------------------------------------
module cartridge_rom_checksum (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  crom_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output crom_pkg::rsp_type rsp_item,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_wr_data
);

   logic                  in_valid_ff;
   crom_pkg::req_type     in_ff;

   logic                  consume, in_ready, fin_ready;
   logic                  data_fire, key_wr;
   crom_pkg::word_type    key_word;
   crom_pkg::variant_type variant;
   crom_pkg::acc_type     acc_next;
   crom_pkg::count_type   count_next;

   // input register leaves when its item can be handled this cycle
   assign consume   = in_valid_ff &&
                      ((in_ff.op == crom_pkg::OP_LOAD) || !in_ff.last || fin_ready);
   assign in_ready  = !in_valid_ff || consume;
   assign req_stall = !in_ready;
   assign data_fire = consume && (in_ff.op == crom_pkg::OP_DATA);
   assign key_wr    = consume && (in_ff.op == crom_pkg::OP_LOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_valid) begin
         in_ff <= req_item;
      end
   end

   // key table, read at the count the next data word will use
   crom_key_ram u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr),
      .wr_addr (in_ff.key_index),
      .wr_data (in_ff.word),
      .rd_addr (count_next),
      .rd_data (key_word)
   );

   // accumulators
   crom_acc u_acc (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (data_fire),
      .last        (in_ff.last),
      .word        (in_ff.word),
      .key_word    (key_word),
      .variant     (variant),
      .acc_next    (acc_next),
      .count_next  (count_next)
   );

   // finishing rule and result register
   crom_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .start     (data_fire && in_ff.last),
      .snap      (acc_next),
      .variant   (variant),
      .ready     (fin_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

>>> hw/rtl/crom_key_ram.sv
// ----------------------------------------------------------------------------
// crom_key_ram
// Key table: one write port, one registered read port with write bypass.
// ----------------------------------------------------------------------------
module crom_key_ram (
   input  logic                clock,
   input  logic                wr_en,
   input  crom_pkg::count_type wr_addr,
   input  crom_pkg::word_type  wr_data,
   input  crom_pkg::count_type rd_addr,
   output crom_pkg::word_type  rd_data
);

   crom_pkg::word_type mem [crom_pkg::KEY_WORDS];
   crom_pkg::word_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, a same-edge write to the read address is passed through
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/crom_acc.sv
// ----------------------------------------------------------------------------
// crom_acc
// Variant register, six accumulators and word counter, one data word a cycle when fire is high.
// ----------------------------------------------------------------------------
module crom_acc (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [1:0]             csr_wr_data,
   input  logic                   fire,
   input  logic                   last,
   input  crom_pkg::word_type     word,
   input  crom_pkg::word_type     key_word,
   output crom_pkg::variant_type  variant,
   output crom_pkg::acc_type      acc_next,
   output crom_pkg::count_type    count_next
);

   crom_pkg::variant_type variant_ff, variant_in;
   crom_pkg::acc_type     acc_ff, acc_in, upd;
   crom_pkg::count_type   count_ff, count_in;

   logic                  carry_out;
   crom_pkg::word_type    rot_word;

   // fold one data word into the accumulators
   always_comb begin
      {carry_out, upd.sum} = {1'b0, acc_ff.sum} + {1'b0, word};
      upd.carry = acc_ff.carry + {31'd0, carry_out};
      upd.xr    = acc_ff.xr ^ word;
      rot_word  = crom_pkg::rotl(word, word[4:0]);
      upd.rot   = acc_ff.rot + rot_word;
      if (acc_ff.cmp > word) begin
         upd.cmp = acc_ff.cmp ^ rot_word;
      end else begin
         upd.cmp = acc_ff.cmp ^ upd.sum ^ word;
      end
      if (variant_ff == crom_pkg::VAR_6105) begin
         upd.mix = acc_ff.mix + (key_word ^ word);
      end else begin
         upd.mix = acc_ff.mix + (upd.rot ^ word);
      end
   end

   // next state: a register write reseeds, the last word reseeds, any other data word folds in
   always_comb begin
      variant_in = variant_ff;
      acc_in     = acc_ff;
      count_in   = count_ff;
      priority if (csr_wr_en) begin
         variant_in = crom_pkg::variant_type'(csr_wr_data);
         acc_in     = crom_pkg::seeded(crom_pkg::seed_of(variant_in));
         count_in   = '0;
      end else if (fire) begin
         if (last) begin
            acc_in   = crom_pkg::seeded(crom_pkg::seed_of(variant_ff));
            count_in = '0;
         end else begin
            acc_in   = upd;
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff <= crom_pkg::VAR_6102;
         acc_ff     <= crom_pkg::seeded(crom_pkg::SEED_6102);
         count_ff   <= '0;
      end else begin
         variant_ff <= variant_in;
         acc_ff     <= acc_in;
         count_ff   <= count_in;
      end
   end

   assign variant    = variant_ff;
   assign acc_next   = upd;
   assign count_next = count_in;

   // a register write starts a fresh region
   a_csr_clears_count: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (count_ff == '0))
      else $error("word count not cleared by register write");

   // the last word leaves the accumulators at the seed
   a_last_reseeds: assert property (@(posedge clock) disable iff (reset)
      (fire && last && !csr_wr_en) |=>
         (acc_ff == crom_pkg::seeded(crom_pkg::seed_of(variant_ff))))
      else $error("accumulators not reseeded after last word");

   // a word that is not last advances the count by one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (fire && !last && !csr_wr_en) |=>
         (count_ff == crom_pkg::count_type'($past(count_ff) + 1'b1)))
      else $error("word count did not advance");

endmodule

>>> hw/rtl/crom_finish.sv
// ----------------------------------------------------------------------------
// crom_finish
// Three-stage finish: snapshot, multiply or xor, add or xor into the output.
// ----------------------------------------------------------------------------
module crom_finish (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  crom_pkg::acc_type     snap,
   input  crom_pkg::variant_type variant,
   output logic                  ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output crom_pkg::rsp_type     rsp_item
);

   // snapshot stage
   logic                  snap_valid_ff;
   crom_pkg::acc_type     snap_ff;
   crom_pkg::variant_type snap_var_ff;

   // product stage
   logic                  prod_valid_ff;
   crom_pkg::word_type    p_first_ff, p_first_in;
   crom_pkg::word_type    p_second_ff, p_second_in;
   crom_pkg::word_type    p_xr_ff;
   crom_pkg::word_type    p_mix_ff;
   crom_pkg::variant_type p_var_ff;

   // output stage
   logic                  out_valid_ff;
   crom_pkg::rsp_type     out_ff, out_in;

   logic                  out_ready, prod_ready, snap_ready;

   assign out_ready  = !out_valid_ff || !rsp_stall;
   assign prod_ready = !prod_valid_ff || out_ready;
   assign snap_ready = !snap_valid_ff || prod_ready;
   assign ready      = snap_ready;

   // first combine: products for 6106, xor otherwise
   always_comb begin
      unique case (snap_var_ff)
         crom_pkg::VAR_6106: begin
            p_first_in  = snap_ff.sum * snap_ff.carry;
            p_second_in = snap_ff.rot * snap_ff.cmp;
         end
         default: begin
            p_first_in  = snap_ff.sum ^ snap_ff.carry;
            p_second_in = snap_ff.rot ^ snap_ff.cmp;
         end
      endcase
   end

   // second combine: add for 6103 and 6106, xor otherwise
   always_comb begin
      if ((p_var_ff == crom_pkg::VAR_6103) || (p_var_ff == crom_pkg::VAR_6106)) begin
         out_in.sum_first  = p_first_ff + p_xr_ff;
         out_in.sum_second = p_second_ff + p_mix_ff;
      end else begin
         out_in.sum_first  = p_first_ff ^ p_xr_ff;
         out_in.sum_second = p_second_ff ^ p_mix_ff;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (snap_ready) begin
            snap_valid_ff <= start;
         end
         if (prod_ready) begin
            prod_valid_ff <= snap_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= prod_valid_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (snap_ready && start) begin
         snap_ff     <= snap;
         snap_var_ff <= variant;
      end
      if (prod_ready && snap_valid_ff) begin
         p_first_ff  <= p_first_in;
         p_second_ff <= p_second_in;
         p_xr_ff     <= snap_ff.xr;
         p_mix_ff    <= snap_ff.mix;
         p_var_ff    <= snap_var_ff;
      end
      if (out_ready && prod_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the six-accumulator ROM header checksum. A short
// table of directed items (word extremes, key loads, rotate by zero, each
// boot variant) runs first, then random regions under every variant. Each
// accepted item is folded into a local copy of the accumulators; each
// checksum result is compared with the oldest predicted pair. Both channels
// idle at random, and the result side holds off long enough to back up
// the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int ITEMS_PER_PHASE = 250;
   localparam int PHASES          = 8;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_CYCLES     = 400;
   localparam int STUCK_LIMIT     = 4000;
   localparam int DIR_ROWS        = 22;
   localparam crom_pkg::rsp_type NO_SUMS = '0;

   // one row of the directed table
   typedef struct packed {
      crom_pkg::variant_type v;
      crom_pkg::req_type     item;
      logic                  known;
      crom_pkg::rsp_type     sums;
   } dir_row_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   crom_pkg::req_type     req_item    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   crom_pkg::rsp_type     rsp_item;
   logic                  csr_wr_en   = 1'b0;
   logic [1:0]            csr_wr_data = '0;

   // predicted state of the block
   crom_pkg::variant_type cur_variant = crom_pkg::VAR_6102;
   crom_pkg::acc_type     acc;
   crom_pkg::count_type   word_count;
   crom_pkg::word_type    key_table [crom_pkg::KEY_WORDS];
   bit                    key_loaded [crom_pkg::KEY_WORDS];

   crom_pkg::rsp_type     expected_sums [$];
   crom_pkg::rsp_type     due_sums;
   int                    mismatches   = 0;
   int                    results_seen = 0;
   int                    hold_left    = 0;
   int                    stuck_cycles = 0;
   int                    words_left   = 0;
   bit                    calm         = 1'b0;

   crom_pkg::variant_type phase_variant [PHASES] = '{
      crom_pkg::VAR_6105, crom_pkg::VAR_6103, crom_pkg::VAR_6106, crom_pkg::VAR_6102,
      crom_pkg::VAR_6105, crom_pkg::VAR_6106, crom_pkg::VAR_6103, crom_pkg::VAR_6105
   };

   // directed items; sums typed in only where they follow from the seed alone
   dir_row_type dir_table [DIR_ROWS] = '{
      '{crom_pkg::VAR_6102, '{crom_pkg::OP_DATA, 32'h00000000, 6'd0,  1'b1}, 1'b1,
        '{32'hF8CA4DDC, 32'hF1949BB8}},
      '{crom_pkg::VAR_6102, '{crom_pkg::OP_LOAD, 32'hFFFFFFFF, 6'd63, 1'b1}, 1'b0, NO_SUMS},
      '{crom_pkg::VAR_6102, '{crom_pkg::OP_LOAD, 32'h00000000, 6'd0,  1'b0}, 1'b0, NO_SUMS},
      '{crom_pkg::VAR_6102, '{crom_pkg::OP_DATA, 32'hFFFFFFFF, 6'd63, 1'b0}, 1'b0, NO_SUMS},
      '{crom_pkg::VAR_6102, '{crom_pkg::OP_DATA, 32'h12345680, 6'd0,  1'b0}, 1'b0, NO_SUMS},
      '{crom_pkg::VAR_6102, '{crom_pkg::OP_DATA, 32'h00000001, 6'd0,  1'b0}, 1'b0, NO_SUMS},
      '{crom_pkg::VAR_6102, '{crom_pkg::OP_DATA, 32'h80000000, 6'd0,  1'b1}, 1'b0, NO_SUMS},
      '{crom_pkg::VAR_6103, '{crom_pkg::OP_DATA, 32'h00000000, 6'd0,  1'b1}, 1'b1,
        '{32'hA3886759, 32'h4710CEB2}},
      '{crom_pkg::VAR_6103, '{crom_pkg::OP_DATA, 32'hFFFFFFFF, 6'd0,  1'b0}, 1'b0, NO_SUMS},
      '{crom_pkg::VAR_6103, '{crom_pkg::OP_DATA, 32'h7FFFFFFF, 6'd0,  1'b1}, 1'b0, NO_SUMS},
      '{crom_pkg::VAR_6105, '{crom_pkg::OP_LOAD, 32'h00000000, 6'd0,  1'b0}, 1'b0, NO_SUMS},
      '{crom_pkg::VAR_6105, '{crom_pkg::OP_DATA, 32'h00000000, 6'd63, 1'b1}, 1'b1,
        '{32'hDF26F436, 32'hDF26F436}},
      '{crom_pkg::VAR_6105, '{crom_pkg::OP_LOAD, 32'hA5A5A5A5, 6'd1,  1'b1}, 1'b0, NO_SUMS},
      '{crom_pkg::VAR_6105, '{crom_pkg::OP_LOAD, 32'h5A5A5A5A, 6'd2,  1'b0}, 1'b0, NO_SUMS},
      '{crom_pkg::VAR_6105, '{crom_pkg::OP_DATA, 32'h5A5A5A5A, 6'd0,  1'b0}, 1'b0, NO_SUMS},
      '{crom_pkg::VAR_6105, '{crom_pkg::OP_DATA, 32'hFFFFFFFF, 6'd0,  1'b0}, 1'b0, NO_SUMS},
      '{crom_pkg::VAR_6105, '{crom_pkg::OP_DATA, 32'h0000001F, 6'd0,  1'b1}, 1'b0, NO_SUMS},
      '{crom_pkg::VAR_6106, '{crom_pkg::OP_DATA, 32'h00000000, 6'd0,  1'b1}, 1'b0, NO_SUMS},
      '{crom_pkg::VAR_6106, '{crom_pkg::OP_DATA, 32'hFFFFFFFF, 6'd0,  1'b0}, 1'b0, NO_SUMS},
      '{crom_pkg::VAR_6106, '{crom_pkg::OP_DATA, 32'h00000001, 6'd0,  1'b0}, 1'b0, NO_SUMS},
      '{crom_pkg::VAR_6106, '{crom_pkg::OP_DATA, 32'hDEADBEEF, 6'd0,  1'b1}, 1'b0, NO_SUMS},
      '{crom_pkg::VAR_6102, '{crom_pkg::OP_DATA, 32'h00000020, 6'd0,  1'b1}, 1'b0, NO_SUMS}
   };

   cartridge_rom_checksum u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // seed word of a boot variant
   function automatic crom_pkg::word_type variant_seed(input crom_pkg::variant_type v);
      unique case (v)
         crom_pkg::VAR_6103: return crom_pkg::SEED_6103;
         crom_pkg::VAR_6105: return crom_pkg::SEED_6105;
         crom_pkg::VAR_6106: return crom_pkg::SEED_6106;
         default:            return crom_pkg::SEED_6102;
      endcase
   endfunction

   // all accumulators back to the seed, fresh region
   function automatic void restart_region();
      crom_pkg::word_type s;
      s          = variant_seed(cur_variant);
      acc        = {6{s}};
      word_count = '0;
   endfunction

   // fold one item into the predicted state; returns 1 when it yields sums
   function automatic bit fold_item(input crom_pkg::req_type it,
                                    output crom_pkg::rsp_type sums);
      crom_pkg::word_type d;
      crom_pkg::word_type x;
      crom_pkg::word_type r;
      crom_pkg::word_type f;
      crom_pkg::word_type s;
      sums = '0;
      if (it.op == crom_pkg::OP_LOAD) begin
         key_table[it.key_index]  = it.word;
         key_loaded[it.key_index] = 1'b1;
         return 1'b0;
      end
      d = it.word;
      x = acc.sum + d;
      if (x < acc.sum) acc.carry = acc.carry + 32'd1;
      acc.sum = x;
      acc.xr  = acc.xr ^ d;
      // rotate left by the word's own low five bits
      if (d[4:0] == 5'd0) r = d;
      else r = (d << d[4:0]) | (d >> (6'd32 - {1'b0, d[4:0]}));
      acc.rot = acc.rot + r;
      if (acc.cmp > d) acc.cmp = acc.cmp ^ r;
      else acc.cmp = acc.cmp ^ acc.sum ^ d;
      if (cur_variant == crom_pkg::VAR_6105) begin
         acc.mix = acc.mix + (key_table[word_count] ^ d);
      end else begin
         acc.mix = acc.mix + (acc.rot ^ d);
      end
      word_count = word_count + 1'b1;
      if (!it.last) return 1'b0;
      // finishing rule of the variant
      unique case (cur_variant)
         crom_pkg::VAR_6103: begin
            f = (acc.sum ^ acc.carry) + acc.xr;
            s = (acc.rot ^ acc.cmp) + acc.mix;
         end
         crom_pkg::VAR_6106: begin
            f = acc.sum * acc.carry + acc.xr;
            s = acc.rot * acc.cmp + acc.mix;
         end
         default: begin
            f = acc.sum ^ acc.carry ^ acc.xr;
            s = acc.rot ^ acc.cmp ^ acc.mix;
         end
      endcase
      sums.sum_first  = f;
      sums.sum_second = s;
      restart_region();
      return 1'b1;
   endfunction

   // word with a bias toward extremes and zero rotate amounts
   function automatic crom_pkg::word_type pick_word();
      unique case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return crom_pkg::word_type'($urandom) & ~32'h1F;
         3:       return 32'h1 << $urandom_range(31);
         default: return crom_pkg::word_type'($urandom);
      endcase
   endfunction

   // next random item: regions of random length, loads mixed in
   function automatic crom_pkg::req_type next_item();
      crom_pkg::req_type it;
      it.op        = crom_pkg::OP_DATA;
      it.word      = pick_word();
      it.key_index = crom_pkg::count_type'($urandom_range(63));
      it.last      = 1'($urandom_range(1));
      // keyed variant never reads a key entry that was not loaded
      if (cur_variant == crom_pkg::VAR_6105 && !key_loaded[word_count]) begin
         it.op        = crom_pkg::OP_LOAD;
         it.key_index = word_count;
         return it;
      end
      if ($urandom_range(9) == 0) begin
         it.op = crom_pkg::OP_LOAD;
         return it;
      end
      if (words_left == 0) begin
         if ($urandom_range(9) == 0) words_left = $urandom_range(60, 130);
         else words_left = $urandom_range(1, 16);
      end
      words_left = words_left - 1;
      it.last    = (words_left == 0);
      return it;
   endfunction

   // offer one item after a random gap, predict once it is taken
   task automatic send_item(input crom_pkg::req_type it, input bit known,
                            input crom_pkg::rsp_type known_sums);
      crom_pkg::rsp_type sums;
      int                gap;
      gap = 0;
      if (!calm) while ($urandom_range(99) < 20) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      if (fold_item(it, sums)) expected_sums.push_back(known ? known_sums : sums);
   endtask

   // change the boot variant once the block has gone quiet
   task automatic set_variant(input crom_pkg::variant_type v);
      req_valid <= 1'b0;
      while (expected_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_variant = v;
      restart_region();
   endtask

   // stimulus
   initial begin
      restart_region();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_table[i]) begin
         if (dir_table[i].v != cur_variant) set_variant(dir_table[i].v);
         send_item(dir_table[i].item, dir_table[i].known, dir_table[i].sums);
      end
      for (int p = 0; p < PHASES; p++) begin
         set_variant(phase_variant[p]);
         calm = (p == 3);
         repeat (ITEMS_PER_PHASE) send_item(next_item(), 1'b0, NO_SUMS);
      end
      calm = 1'b0;
      req_valid <= 1'b0;
      while (expected_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_sums.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // result side: check each item, stall at random, hold off twice
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (expected_sums.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h %h",
                        $time, rsp_item.sum_first, rsp_item.sum_second);
               mismatches++;
            end else begin
               due_sums = expected_sums.pop_front();
               if (rsp_item.sum_first !== due_sums.sum_first) begin
                  $display("%0t: sum_first mismatch, expected %h actual %h",
                           $time, due_sums.sum_first, rsp_item.sum_first);
                  mismatches++;
               end
               if (rsp_item.sum_second !== due_sums.sum_second) begin
                  $display("%0t: sum_second mismatch, expected %h actual %h",
                           $time, due_sums.sum_second, rsp_item.sum_second);
                  mismatches++;
               end
            end
            if (results_seen == 30 || results_seen == 90) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 20);
         end
      end
   end

   // watchdog on cycles where neither channel moves an item
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

endmodule

>>> sim.f
hw/rtl/crom_pkg.sv
hw/rtl/crom_key_ram.sv
hw/rtl/crom_acc.sv
hw/rtl/crom_finish.sv
hw/rtl/cartridge_rom_checksum.sv
dv/testbench.sv
